// ===== design/nll_pkg.sv =====
// Shared types, codes and character constants of the numeric literal lexer.
package nll_pkg;

	localparam int MAX_LEN_DEFAULT = 64;
	localparam int CNT_W = 7;

	// scan modes
	localparam logic [2:0] MODE_IDLE      = 3'd0;
	localparam logic [2:0] MODE_FIRST     = 3'd1;
	localparam logic [2:0] MODE_BIN_START = 3'd2;
	localparam logic [2:0] MODE_BIN       = 3'd3;
	localparam logic [2:0] MODE_HEX_START = 3'd4;
	localparam logic [2:0] MODE_HEX       = 3'd5;
	localparam logic [2:0] MODE_DEC       = 3'd6;

	// result status
	localparam logic [2:0] ST_CONT     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_ERR_EAT  = 3'd2;
	localparam logic [2:0] ST_ERR_KEEP = 3'd3;
	localparam logic [2:0] ST_IDLE     = 3'd4;

	// token classes
	localparam logic [2:0] CL_NONE  = 3'd0;
	localparam logic [2:0] CL_BIN   = 3'd1;
	localparam logic [2:0] CL_HEX   = 3'd2;
	localparam logic [2:0] CL_DEC   = 3'd3;
	localparam logic [2:0] CL_FLOAT = 3'd4;

	// error kinds
	localparam logic [3:0] ERR_NONE          = 4'd0;
	localparam logic [3:0] ERR_SEP_START     = 4'd1;
	localparam logic [3:0] ERR_SEP_REPEAT    = 4'd2;
	localparam logic [3:0] ERR_SEP_END       = 4'd3;
	localparam logic [3:0] ERR_SEP_MANTISSA  = 4'd4;
	localparam logic [3:0] ERR_MULTI_PERIOD  = 4'd5;
	localparam logic [3:0] ERR_EXP_IN_DEC    = 4'd6;
	localparam logic [3:0] ERR_MULTI_EXP     = 4'd7;
	localparam logic [3:0] ERR_EXP_POS       = 4'd8;
	localparam logic [3:0] ERR_SIGN_IN_DEC   = 4'd9;
	localparam logic [3:0] ERR_MULTI_SIGN    = 4'd10;
	localparam logic [3:0] ERR_SIGN_POS      = 4'd11;

	// characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SEP   = 8'h27;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic       start_req;
		logic [7:0] char_code;
		logic       end_of_input;
	} char_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [2:0]       token_class;
		logic [3:0]       error_kind;
		logic [CNT_W-1:0] length;
	} tok_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [CNT_W-1:0] count;
		logic             last_sep;
		logic             last_digit;
		logic             last_exp;
		logic             period_seen;
		logic             exp_seen;
		logic             sign_seen;
	} scan_state_t;

	localparam scan_state_t STATE_CLEAR = '{
		mode: MODE_IDLE, count: '0, last_sep: 1'b0, last_digit: 1'b0,
		last_exp: 1'b0, period_seen: 1'b0, exp_seen: 1'b0, sign_seen: 1'b0
	};

endpackage

// ===== design/numeric_literal_lexer.sv =====
// Top level of the numeric literal lexer: input stage, scan state and result register.
//
//  channel | direction | handshake              | payload
//  char    | in        | char_valid, char_ready | char_data (nll_pkg::char_t)
//  tok     | out       | tok_valid, tok_ready   | tok_data  (nll_pkg::tok_t)
//
// One character per cycle sustained while the result side does not stall; each result is set by
// the result register behind the scan step that reads the input register.
// The scan state advances in the same cycle as the character moves into the result register.
// Reset (arst_n low) returns the scanner to idle with the count and all flags cleared.
// A stalled result holds the result register; one further character waits in the input register.
module numeric_literal_lexer #(
	parameter int MAX_LEN = nll_pkg::MAX_LEN_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	output logic           char_ready,
	input  nll_pkg::char_t char_data,
	output logic           tok_valid,
	input  logic           tok_ready,
	output nll_pkg::tok_t  tok_data
);

	nll_pkg::char_t       char_s1;
	logic                 char_valid_s1;
	nll_pkg::tok_t        tok_s2;
	logic                 tok_valid_s2;
	nll_pkg::scan_state_t state_q, state_nxt;
	nll_pkg::tok_t        step_tok;
	logic                 advance;

	assign advance    = char_valid_s1 && (!tok_valid_s2 || tok_ready);
	assign char_ready = !char_valid_s1 || advance;

	nll_step #(
		.MAX_LEN(MAX_LEN)
	) u_step (
		.st (state_q),
		.ch (char_s1),
		.nxt(state_nxt),
		.tok(step_tok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
			tok_valid_s2  <= 1'b0;
			state_q       <= nll_pkg::STATE_CLEAR;
		end else begin
			if (char_ready)
				char_valid_s1 <= char_valid;
			if (advance) begin
				tok_valid_s2 <= 1'b1;
				state_q      <= state_nxt;
			end else if (tok_ready) begin
				tok_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready)
			char_s1 <= char_data;
		if (advance)
			tok_s2 <= step_tok;
	end

	assign tok_valid = tok_valid_s2;
	assign tok_data  = tok_s2;

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> tok_valid_s2)
		else $error("result register not filled after a step");

	a_open_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode != nll_pkg::MODE_IDLE) |-> (state_q.count != '0))
		else $error("open literal with zero length");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count <= nll_pkg::CNT_W'(MAX_LEN))
		else $error("length above maximum");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_tok.status != nll_pkg::ST_CONT) |=>
		(state_q.mode == nll_pkg::MODE_IDLE && state_q.count == '0))
		else $error("scanner not cleared after end of literal");

	a_class_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid_s2 |-> (tok_s2.status == nll_pkg::ST_DONE ||
		                  tok_s2.token_class == nll_pkg::CL_NONE))
		else $error("class reported on a result that is not done");

endmodule

// ===== design/nll_step.sv =====
// One-character scan step: next scan state and the result for the character.
module nll_step #(
	parameter int MAX_LEN = nll_pkg::MAX_LEN_DEFAULT
) (
	input  nll_pkg::scan_state_t st,
	input  nll_pkg::char_t       ch,
	output nll_pkg::scan_state_t nxt,
	output nll_pkg::tok_t        tok
);

	logic [7:0] c;
	logic       eoi;
	logic       is_dec, is_sep, is_dot, is_exp, is_sign, is_hexl, rdigit;
	logic       hex, rstart, dec_path, bump_en;
	logic [2:0] status, cls;
	logic [3:0] err;
	logic [nll_pkg::CNT_W-1:0] cnt_out;

	assign c       = ch.char_code;
	assign eoi     = ch.end_of_input;
	assign is_dec  = (c >= nll_pkg::CH_ZERO) && (c <= nll_pkg::CH_NINE);
	assign is_hexl = (c >= nll_pkg::CH_UP_A) && (c <= nll_pkg::CH_UP_F);
	assign is_sep  = (c == nll_pkg::CH_SEP);
	assign is_dot  = (c == nll_pkg::CH_DOT);
	assign is_exp  = (c == nll_pkg::CH_LOW_E);
	assign is_sign = (c == nll_pkg::CH_PLUS) || (c == nll_pkg::CH_MINUS);
	assign hex     = (st.mode == nll_pkg::MODE_HEX_START) || (st.mode == nll_pkg::MODE_HEX);
	assign rstart  = (st.mode == nll_pkg::MODE_BIN_START) ||
	                 (st.mode == nll_pkg::MODE_HEX_START);
	assign rdigit  = hex ? (is_dec || is_hexl)
	                     : ((c == nll_pkg::CH_ZERO) || (c == nll_pkg::CH_ONE));

	always_comb begin
		nxt      = st;
		status   = nll_pkg::ST_CONT;
		cls      = nll_pkg::CL_NONE;
		err      = nll_pkg::ERR_NONE;
		bump_en  = 1'b0;
		dec_path = 1'b0;
		cnt_out  = '0;

		unique case (st.mode)
			nll_pkg::MODE_FIRST: begin
				priority if (!eoi && c == nll_pkg::CH_LOW_B) begin
					nxt.mode = nll_pkg::MODE_BIN_START;
					bump_en  = 1'b1;
				end else if (!eoi && c == nll_pkg::CH_LOW_X) begin
					nxt.mode = nll_pkg::MODE_HEX_START;
					bump_en  = 1'b1;
				end else if (!eoi && (is_dec || is_dot || is_sep)) begin
					dec_path = 1'b1;
				end else begin
					// lone digit: decimal, terminator left for the next literal
					status = nll_pkg::ST_DONE;
					cls    = nll_pkg::CL_DEC;
				end
			end
			nll_pkg::MODE_BIN_START, nll_pkg::MODE_BIN,
			nll_pkg::MODE_HEX_START, nll_pkg::MODE_HEX: begin
				priority if (!eoi && rstart && is_sep) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_SEP_START;
				end else begin
					nxt.mode = hex ? nll_pkg::MODE_HEX : nll_pkg::MODE_BIN;
					priority if (eoi || (!rdigit && !is_sep)) begin
						if (st.last_sep) begin
							status = nll_pkg::ST_ERR_KEEP;
							err    = nll_pkg::ERR_SEP_END;
						end else begin
							status = nll_pkg::ST_DONE;
							cls    = hex ? nll_pkg::CL_HEX : nll_pkg::CL_BIN;
						end
					end else if (is_sep && st.last_sep) begin
						status = nll_pkg::ST_ERR_EAT;
						err    = nll_pkg::ERR_SEP_REPEAT;
					end else begin
						nxt.last_sep = is_sep;
						bump_en      = 1'b1;
					end
				end
			end
			nll_pkg::MODE_DEC: begin
				dec_path = 1'b1;
			end
			default: begin
				nxt = nll_pkg::STATE_CLEAR;
				if (ch.start_req && !eoi && is_dec) begin
					nxt.mode       = nll_pkg::MODE_FIRST;
					nxt.last_digit = 1'b1;
					bump_en        = 1'b1;
				end else begin
					status = nll_pkg::ST_IDLE;
				end
			end
		endcase

		if (dec_path) begin
			nxt.mode = nll_pkg::MODE_DEC;
			priority if (eoi || !(is_dec || is_dot || is_sep || is_exp || is_sign)) begin
				if (st.last_sep) begin
					status = nll_pkg::ST_ERR_KEEP;
					err    = nll_pkg::ERR_SEP_END;
				end else begin
					status = nll_pkg::ST_DONE;
					cls    = st.period_seen ? nll_pkg::CL_FLOAT : nll_pkg::CL_DEC;
				end
			end else if (is_dot) begin
				priority if (st.last_sep) begin
					status = nll_pkg::ST_ERR_KEEP;
					err    = nll_pkg::ERR_SEP_END;
				end else if (st.period_seen) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_MULTI_PERIOD;
				end else begin
					nxt.period_seen = 1'b1;
				end
			end else if (is_sep) begin
				priority if (st.last_sep) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_SEP_REPEAT;
				end else if (st.period_seen || st.exp_seen) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_SEP_MANTISSA;
				end else begin
					// single separator in the integer part: accept
				end
			end else if (is_exp) begin
				priority if (!st.period_seen) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_EXP_IN_DEC;
				end else if (st.exp_seen) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_MULTI_EXP;
				end else if (!st.last_digit) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_EXP_POS;
				end else begin
					nxt.exp_seen = 1'b1;
				end
			end else if (is_sign) begin
				priority if (!st.period_seen) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_SIGN_IN_DEC;
				end else if (st.sign_seen) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_MULTI_SIGN;
				end else if (!st.last_exp) begin
					status = nll_pkg::ST_ERR_EAT;
					err    = nll_pkg::ERR_SIGN_POS;
				end else begin
					nxt.sign_seen = 1'b1;
				end
			end else begin
				// digit: always accepted
			end
			if (status == nll_pkg::ST_CONT) begin
				nxt.last_digit = is_dec;
				nxt.last_sep   = is_sep;
				nxt.last_exp   = is_exp;
				bump_en        = 1'b1;
			end
		end

		// saturate the length at the configured maximum
		if (bump_en && (nxt.count < nll_pkg::CNT_W'(MAX_LEN)))
			nxt.count = nxt.count + 1'b1;

		if (status != nll_pkg::ST_IDLE)
			cnt_out = nxt.count;

		// done or error: drop the literal and return to idle
		if (status != nll_pkg::ST_CONT)
			nxt = nll_pkg::STATE_CLEAR;
	end

	assign tok.status      = status;
	assign tok.token_class = cls;
	assign tok.error_kind  = err;
	assign tok.length      = cnt_out;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the numeric literal lexer: character stimulus, scan predictor, result check.
module tb_top;

	localparam int LEN_CAP  = nll_pkg::MAX_LEN_DEFAULT;
	localparam int END_MARK = 256;   // stands for end of input in a character sequence
	localparam int DIG_BIN  = 0;
	localparam int DIG_HEX  = 1;
	localparam int DIG_DEC  = 2;

	logic           clk;
	logic           arst_n;
	logic           char_valid;
	logic           char_ready;
	nll_pkg::char_t char_data;
	logic           tok_valid;
	logic           tok_ready;
	nll_pkg::tok_t  tok_data;

	numeric_literal_lexer #(.MAX_LEN(LEN_CAP)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_data   (tok_data)
	);

	// mirror of the scan state
	logic [2:0] scan_mode_m = nll_pkg::MODE_IDLE;
	int         char_cnt    = 0;
	logic       prev_sep    = 1'b0;
	logic       prev_digit  = 1'b0;
	logic       prev_exp    = 1'b0;
	logic       has_period  = 1'b0;
	logic       has_exp     = 1'b0;
	logic       has_sign    = 1'b0;

	nll_pkg::tok_t expected_tokens[$];
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	int            chars_sent     = 0;
	int            tokens_checked = 0;
	int            fail_count     = 0;
	bit [15:0]     kinds_seen     = '0;
	bit [7:0]      classes_seen   = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= nll_pkg::CH_ZERO && c <= nll_pkg::CH_NINE;
	endfunction

	function automatic void clear_scan();
		scan_mode_m = nll_pkg::MODE_IDLE;
		char_cnt    = 0;
		prev_sep    = 1'b0;
		prev_digit  = 1'b0;
		prev_exp    = 1'b0;
		has_period  = 1'b0;
		has_exp     = 1'b0;
		has_sign    = 1'b0;
	endfunction

	function automatic void count_char();
		if (char_cnt < LEN_CAP)
			char_cnt++;
	endfunction

	// a trailing separator turns the end of a literal into an error
	function automatic void close_literal(input logic [2:0] cls_in, output logic [2:0] st,
			output logic [2:0] cls, output logic [3:0] err);
		if (prev_sep) begin
			st  = nll_pkg::ST_ERR_KEEP;
			cls = nll_pkg::CL_NONE;
			err = nll_pkg::ERR_SEP_END;
		end else begin
			st  = nll_pkg::ST_DONE;
			cls = cls_in;
			err = nll_pkg::ERR_NONE;
		end
	endfunction

	function automatic void scan_decimal(input logic [7:0] c, input logic eoi,
			output logic [2:0] st, output logic [2:0] cls, output logic [3:0] err);
		logic sign_c;
		st     = nll_pkg::ST_CONT;
		cls    = nll_pkg::CL_NONE;
		err    = nll_pkg::ERR_NONE;
		sign_c = (c == nll_pkg::CH_PLUS) || (c == nll_pkg::CH_MINUS);
		if (eoi || !(is_digit(c) || c == nll_pkg::CH_DOT || c == nll_pkg::CH_SEP ||
				c == nll_pkg::CH_LOW_E || sign_c)) begin
			close_literal(has_period ? nll_pkg::CL_FLOAT : nll_pkg::CL_DEC, st, cls, err);
			return;
		end
		if (c == nll_pkg::CH_DOT) begin
			if (prev_sep) begin
				st  = nll_pkg::ST_ERR_KEEP;
				err = nll_pkg::ERR_SEP_END;
			end else if (has_period) begin
				st  = nll_pkg::ST_ERR_EAT;
				err = nll_pkg::ERR_MULTI_PERIOD;
			end else
				has_period = 1'b1;
		end else if (c == nll_pkg::CH_SEP) begin
			if (prev_sep) begin
				st  = nll_pkg::ST_ERR_EAT;
				err = nll_pkg::ERR_SEP_REPEAT;
			end else if (has_period || has_exp) begin
				st  = nll_pkg::ST_ERR_EAT;
				err = nll_pkg::ERR_SEP_MANTISSA;
			end
		end else if (c == nll_pkg::CH_LOW_E) begin
			st = nll_pkg::ST_ERR_EAT;
			if (!has_period)
				err = nll_pkg::ERR_EXP_IN_DEC;
			else if (has_exp)
				err = nll_pkg::ERR_MULTI_EXP;
			else if (!prev_digit)
				err = nll_pkg::ERR_EXP_POS;
			else begin
				st      = nll_pkg::ST_CONT;
				has_exp = 1'b1;
			end
		end else if (sign_c) begin
			st = nll_pkg::ST_ERR_EAT;
			if (!has_period)
				err = nll_pkg::ERR_SIGN_IN_DEC;
			else if (has_sign)
				err = nll_pkg::ERR_MULTI_SIGN;
			else if (!prev_exp)
				err = nll_pkg::ERR_SIGN_POS;
			else begin
				st       = nll_pkg::ST_CONT;
				has_sign = 1'b1;
			end
		end
		if (st == nll_pkg::ST_CONT) begin
			prev_digit = is_digit(c);
			prev_sep   = (c == nll_pkg::CH_SEP);
			prev_exp   = (c == nll_pkg::CH_LOW_E);
			count_char();
		end
	endfunction

	// advance the mirror by one character and return the result it calls for
	function automatic nll_pkg::tok_t scan_char(nll_pkg::char_t ch);
		logic [7:0]    c;
		logic          eoi;
		logic          hex_m;
		logic          rad_digit;
		logic [2:0]    st;
		logic [2:0]    cls;
		logic [3:0]    err;
		nll_pkg::tok_t r;
		c     = ch.char_code;
		eoi   = ch.end_of_input;
		st    = nll_pkg::ST_CONT;
		cls   = nll_pkg::CL_NONE;
		err   = nll_pkg::ERR_NONE;
		hex_m = (scan_mode_m == nll_pkg::MODE_HEX_START) || (scan_mode_m == nll_pkg::MODE_HEX);
		case (scan_mode_m)
			nll_pkg::MODE_FIRST: begin
				if (!eoi && c == nll_pkg::CH_LOW_B) begin
					scan_mode_m = nll_pkg::MODE_BIN_START;
					count_char();
				end else if (!eoi && c == nll_pkg::CH_LOW_X) begin
					scan_mode_m = nll_pkg::MODE_HEX_START;
					count_char();
				end else if (!eoi && (is_digit(c) || c == nll_pkg::CH_DOT ||
						c == nll_pkg::CH_SEP)) begin
					scan_mode_m = nll_pkg::MODE_DEC;
					scan_decimal(c, eoi, st, cls, err);
				end else begin
					st  = nll_pkg::ST_DONE;
					cls = nll_pkg::CL_DEC;
				end
			end
			nll_pkg::MODE_BIN_START, nll_pkg::MODE_BIN,
			nll_pkg::MODE_HEX_START, nll_pkg::MODE_HEX: begin
				if (!eoi && c == nll_pkg::CH_SEP &&
						(scan_mode_m == nll_pkg::MODE_BIN_START ||
						 scan_mode_m == nll_pkg::MODE_HEX_START)) begin
					st  = nll_pkg::ST_ERR_EAT;
					err = nll_pkg::ERR_SEP_START;
				end else begin
					scan_mode_m = hex_m ? nll_pkg::MODE_HEX : nll_pkg::MODE_BIN;
					rad_digit   = hex_m ? (is_digit(c) ||
					                       (c >= nll_pkg::CH_UP_A && c <= nll_pkg::CH_UP_F))
					                    : (c == nll_pkg::CH_ZERO || c == nll_pkg::CH_ONE);
					if (eoi || (!rad_digit && c != nll_pkg::CH_SEP))
						close_literal(hex_m ? nll_pkg::CL_HEX : nll_pkg::CL_BIN, st, cls, err);
					else if (c == nll_pkg::CH_SEP && prev_sep) begin
						st  = nll_pkg::ST_ERR_EAT;
						err = nll_pkg::ERR_SEP_REPEAT;
					end else begin
						prev_sep = (c == nll_pkg::CH_SEP);
						count_char();
					end
				end
			end
			nll_pkg::MODE_DEC:
				scan_decimal(c, eoi, st, cls, err);
			default: begin
				clear_scan();
				if (ch.start_req && !eoi && is_digit(c)) begin
					scan_mode_m = nll_pkg::MODE_FIRST;
					prev_digit  = 1'b1;
					count_char();
				end else
					st = nll_pkg::ST_IDLE;
			end
		endcase
		r.status      = st;
		r.token_class = cls;
		r.error_kind  = err;
		r.length      = (st == nll_pkg::ST_IDLE) ? '0 : char_cnt[nll_pkg::CNT_W-1:0];
		if (st != nll_pkg::ST_CONT && st != nll_pkg::ST_IDLE)
			clear_scan();
		return r;
	endfunction

	// hold valid and payload until the transfer, then record what it must produce
	task automatic send_char(input int code, input bit first);
		nll_pkg::char_t ch;
		ch.start_req    = first;
		ch.end_of_input = (code == END_MARK);
		ch.char_code    = ch.end_of_input ? 8'($urandom) : code[7:0];
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= ch;
		do
			@(posedge clk);
		while (!char_ready);
		expected_tokens.push_back(scan_char(ch));
		chars_sent++;
	endtask

	task automatic send_sequence(ref int q[$], input int restart_pct);
		foreach (q[i])
			send_char(q[i], (i == 0) || ($urandom_range(99) < restart_pct));
	endtask

	task automatic check_token(nll_pkg::tok_t got);
		nll_pkg::tok_t want;
		if (expected_tokens.size() == 0) begin
			$error("result with no character pending: status %0d length %0d",
				got.status, got.length);
			fail_count++;
			return;
		end
		want = expected_tokens.pop_front();
		tokens_checked++;
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_count++;
		end
		if (got.token_class !== want.token_class) begin
			$error("token_class: expected %0d, got %0d", want.token_class, got.token_class);
			fail_count++;
		end
		if (got.error_kind !== want.error_kind) begin
			$error("error_kind: expected %0d, got %0d", want.error_kind, got.error_kind);
			fail_count++;
		end
		if (got.length !== want.length) begin
			$error("length: expected %0d, got %0d", want.length, got.length);
			fail_count++;
		end
		if (want.status == nll_pkg::ST_ERR_EAT || want.status == nll_pkg::ST_ERR_KEEP)
			kinds_seen[want.error_kind] = 1'b1;
		if (want.status == nll_pkg::ST_DONE)
			classes_seen[want.token_class] = 1'b1;
	endtask

	initial begin
		tok_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && tok_valid && tok_ready)
				check_token(tok_data);
			tok_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic int pick_digit(int kind);
		int r;
		case (kind)
			DIG_BIN: r = int'(nll_pkg::CH_ZERO) + $urandom_range(1);
			DIG_HEX: begin
				r = $urandom_range(15);
				r = (r < 10) ? int'(nll_pkg::CH_ZERO) + r : int'(nll_pkg::CH_UP_A) + r - 10;
			end
			default: r = int'(nll_pkg::CH_ZERO) + $urandom_range(9);
		endcase
		return r;
	endfunction

	// digit group with single separators between digits only
	function automatic void add_digits(ref int q[$], input int n, input int kind, input int sep_pct);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(99) < sep_pct)
				q.push_back(int'(nll_pkg::CH_SEP));
			q.push_back(pick_digit(kind));
		end
	endfunction

	// mostly well-formed literal with random content, a quarter of them broken at one spot
	function automatic void make_literal(ref int q[$]);
		int pos;
		q.delete();
		case ($urandom_range(3))
			0: begin
				q.push_back(($urandom_range(3) == 0) ? pick_digit(DIG_DEC)
				                                     : int'(nll_pkg::CH_ZERO));
				q.push_back(int'(nll_pkg::CH_LOW_B));
				add_digits(q, $urandom_range(8), DIG_BIN, 20);
			end
			1: begin
				q.push_back(($urandom_range(3) == 0) ? pick_digit(DIG_DEC)
				                                     : int'(nll_pkg::CH_ZERO));
				q.push_back(int'(nll_pkg::CH_LOW_X));
				add_digits(q, $urandom_range(8), DIG_HEX, 20);
			end
			2: add_digits(q, $urandom_range(1, 7), DIG_DEC, 20);
			default: begin
				add_digits(q, $urandom_range(1, 4), DIG_DEC, 15);
				q.push_back(int'(nll_pkg::CH_DOT));
				add_digits(q, $urandom_range(4), DIG_DEC, 3);
				if ($urandom_range(99) < 60) begin
					q.push_back(int'(nll_pkg::CH_LOW_E));
					if ($urandom_range(1))
						q.push_back($urandom_range(1) ? int'(nll_pkg::CH_PLUS)
						                              : int'(nll_pkg::CH_MINUS));
					add_digits(q, $urandom_range(3), DIG_DEC, 3);
				end
			end
		endcase
		if ($urandom_range(99) < 25) begin
			pos = $urandom_range(1, q.size());
			case ($urandom_range(8))
				0: q.insert(pos, int'(nll_pkg::CH_SEP));
				1: q.insert(pos, int'(nll_pkg::CH_DOT));
				2: q.insert(pos, int'(nll_pkg::CH_LOW_E));
				3: q.insert(pos, int'(nll_pkg::CH_PLUS));
				4: q.insert(pos, int'(nll_pkg::CH_MINUS));
				5: q.insert(pos, int'(nll_pkg::CH_LOW_B));
				6: q.insert(pos, int'(nll_pkg::CH_LOW_X));
				7: q.insert(pos, END_MARK);
				default: q.insert(pos, $urandom_range(255));
			endcase
		end
		case ($urandom_range(5))
			0: q.push_back(END_MARK);
			1: q.push_back(int'(" "));
			2: q.push_back(int'(";"));
			3: q.push_back(int'(")"));
			4: q.push_back(int'("a") + $urandom_range(5));
			default: q.push_back($urandom_range(255));
		endcase
	endfunction

	task automatic test_special_cases();
		// ignored in idle: no start mark, and end of input even with one
		send_char(255, 1'b0);
		send_char(END_MARK, 1'b1);
		// lone digit ends on a space
		send_char(int'("5"), 1'b1);
		send_char(int'(" "), 1'b0);
		// start mark inside a hex literal changes nothing
		send_char(int'(nll_pkg::CH_ZERO), 1'b1);
		send_char(int'(nll_pkg::CH_LOW_X), 1'b0);
		send_char(int'(nll_pkg::CH_NINE), 1'b1);
		send_char(int'(nll_pkg::CH_UP_F), 1'b0);
		send_char(END_MARK, 1'b0);
		// empty binary body
		send_char(int'(nll_pkg::CH_ONE), 1'b1);
		send_char(int'(nll_pkg::CH_LOW_B), 1'b0);
		send_char(END_MARK, 1'b0);
		// float that stops after its exponent sign, then after its exponent
		send_char(int'(nll_pkg::CH_ONE), 1'b1);
		send_char(int'(nll_pkg::CH_DOT), 1'b0);
		send_char(int'("5"), 1'b0);
		send_char(int'(nll_pkg::CH_LOW_E), 1'b0);
		send_char(int'(nll_pkg::CH_PLUS), 1'b0);
		send_char(END_MARK, 1'b0);
		send_char(int'(nll_pkg::CH_NINE), 1'b1);
		send_char(int'(nll_pkg::CH_DOT), 1'b0);
		send_char(int'(nll_pkg::CH_ZERO), 1'b0);
		send_char(int'(nll_pkg::CH_LOW_E), 1'b0);
		send_char(0, 1'b0);
	endtask

	task automatic test_literal_stream(input int n_chars);
		int q[$];
		int target;
		target = chars_sent + n_chars;
		while (chars_sent < target) begin
			make_literal(q);
			if ($urandom_range(99) < 20)
				send_char($urandom_range(255), 1'b0);
			send_sequence(q, 8);
		end
	endtask

	task automatic test_length_saturation();
		int q[$];
		for (int k = 0; k < 4; k++) begin
			q.delete();
			if (k[0]) begin
				q.push_back(int'(nll_pkg::CH_ZERO));
				q.push_back(int'(nll_pkg::CH_LOW_B));
				add_digits(q, $urandom_range(LEN_CAP - 4, LEN_CAP + 12), DIG_BIN, 0);
			end else
				add_digits(q, $urandom_range(LEN_CAP - 4, LEN_CAP + 12), DIG_DEC, 5);
			q.push_back((k == 3) ? END_MARK : int'(" "));
			send_sequence(q, 0);
		end
	endtask

	task automatic test_noise_stream(input int n_chars);
		for (int i = 0; i < n_chars; i++)
			send_char(($urandom_range(9) == 0) ? END_MARK : $urandom_range(255),
				1'($urandom_range(1)));
	endtask

	initial begin
		int waited;
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_literal_stream(350);
		send_idle_pct  = 73;
		test_literal_stream(350);
		send_idle_pct  = 0;
		recv_stall_pct = 73;
		test_literal_stream(350);
		send_idle_pct  = 22;
		recv_stall_pct = 22;
		test_literal_stream(350);
		test_length_saturation();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_noise_stream(200);

		// drain outstanding results, then allow for any stray ones
		char_valid <= 1'b0;
		waited = 0;
		while (expected_tokens.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_tokens.size() != 0) begin
			$error("%0d results never arrived", expected_tokens.size());
			fail_count++;
		end
		repeat (8) @(posedge clk);

		$display("%0d characters sent, %0d results checked over four flow-control phases",
			chars_sent, tokens_checked);
		$display("%0d of 11 error kinds and %0d of 4 literal classes seen",
			$countones(kinds_seen), $countones(classes_seen));
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
